// ----- rtl/core/scanline_polygon_span_fill_unit_defines.svh -----
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_unit_defines
// Assertion macros shared by the span fill unit.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_POLYGON_SPAN_FILL_UNIT_DEFINES_SVH
`define SCANLINE_POLYGON_SPAN_FILL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SPF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define SPF_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define SPF_ASSERT_IMP(label, clk, rst, a, c)
`define SPF_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- rtl/core/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and codes of the span fill unit.
// ----------------------------------------------------------------------------
`default_nettype none
package spf_pkg;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EDGE, ST_DIV, ST_INS, ST_EMIT, ST_SHIFT
  } state_t;

  // control word from sequencer to the cell chain
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } chain_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/scanline_polygon_span_fill_unit.sv -----
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_unit
// Even-odd polygon span generator with a vertex store and a sorted
// crossing chain.
// ----------------------------------------------------------------------------
// A command word is taken on start while busy is low. A vertex load keeps
// busy high for one cycle and its status word comes out in the cycle after
// the accept. A row request clears the crossing chain and walks the N stored
// edges (none with fewer than three vertices): each edge takes two registered
// store reads and the row test, and an edge that crosses the row then goes
// through the 34-step divider and the insert into the chain. After the walk
// the spans, one per pair of crossings, come out in turn with the chain
// shifting toward the head, or a single empty word when there is no pair.
// The receiver cannot stall: each word is shown on done for one cycle only,
// so sample it then.
`default_nettype none
`include "scanline_polygon_span_fill_unit_defines.svh"
module scanline_polygon_span_fill_unit #(
  parameter int MAX_CROSSINGS = 16,
  parameter int MAX_VERTICES  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic        restart_list,
  input  wire logic signed [15:0] vertex_x,
  input  wire logic signed [15:0] vertex_y,
  input  wire logic signed [15:0] row_y,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  output logic             done,
  output logic             span_valid,
  output logic signed [15:0] span_x,
  output logic signed [15:0] span_y,
  output logic [15:0]      span_length,
  output logic [7:0]       span_color,
  output logic             last_result,
  output logic [6:0]       vertex_total,
  output logic signed [15:0] extent_low_y,
  output logic signed [15:0] extent_high_y,
  output logic             vertex_dropped
);
  import spf_pkg::*;
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_CROSSINGS + 1);

  state_t state, state_next;
  logic [7:0] fill_color;
  logic [VW-1:0] vcount;
  logic signed [15:0] low_y, high_y;
  logic [CW-1:0] ccount;
  logic [VW-1:0] edge_i;
  logic [1:0] fphase;
  logic signed [15:0] row;
  logic signed [15:0] xmem [MAX_VERTICES];
  logic signed [15:0] ymem [MAX_VERTICES];
  logic signed [15:0] rd_x, rd_y, x0, y0, x1, y1;
  logic [AW-1:0] rd_addr;
  logic signed [34:0] num;
  logic [16:0] den;
  logic signed [15:0] base_x;
  logic div_start, div_done;
  logic signed [34:0] quo;
  logic signed [15:0] new_x;
  logic [CW-1:0] pairs_left;
  logic emit_load;
  logic accept;
  logic signed [16:0] dy, dx, dyr;
  logic qual;
  logic signed [33:0] prod;
  logic [MAX_CROSSINGS-1:0] c_full, c_gt;
  logic signed [15:0] c_x [MAX_CROSSINGS];
  chain_ctl_t ctl;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_EMIT);

  // fill color register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) fill_color <= 8'd0;
    else if (cfg_valid && cfg_ready) fill_color <= cfg_data;
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (accept && command == CMD_LOAD && (restart_list || vcount < VW'(MAX_VERTICES))) begin
      xmem[restart_list ? AW'(0) : vcount[AW-1:0]] <= vertex_x;
      ymem[restart_list ? AW'(0) : vcount[AW-1:0]] <= vertex_y;
    end
    rd_x <= xmem[rd_addr];
    rd_y <= ymem[rd_addr];
  end

  // crossing chain, sorted ascending from cell 0
  for (genvar g = 0; g < MAX_CROSSINGS; g++) begin : g_chain
    logic               lf, lg, rf;
    logic signed [15:0] lx, rx;
    if (g == 0) begin : g_head
      assign lf = 1'b1;
      assign lg = 1'b0;
      assign lx = '0;
    end else begin : g_left
      assign lf = c_full[g-1];
      assign lg = c_gt[g-1];
      assign lx = c_x[g-1];
    end
    if (g == MAX_CROSSINGS - 1) begin : g_tail
      assign rf = 1'b0;
      assign rx = '0;
    end else begin : g_right
      assign rf = c_full[g+1];
      assign rx = c_x[g+1];
    end
    spf_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .new_x(new_x),
      .left_full(lf), .left_gt(lg), .left_x(lx),
      .right_full(rf), .right_x(rx),
      .full(c_full[g]), .gt(c_gt[g]), .x(c_x[g])
    );
  end

  spf_div u_div (.clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
                 .done(div_done), .quo(quo));
  assign new_x = 16'(base_x + quo[15:0]);

  // edge fetch address: phase 0 vertex i, later phases vertex j
  always_comb begin
    if (fphase == 2'd0) rd_addr = edge_i[AW-1:0];
    else if (edge_i + VW'(1) < vcount) rd_addr = AW'(edge_i + VW'(1));
    else rd_addr = '0;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and chain control
  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_LOAD || vcount < VW'(3)) state_next = ST_EMIT;
          else state_next = ST_FETCH;
          if (command == CMD_ROW) ctl.clear = 1'b1;
        end
      end
      ST_FETCH: begin
        if (fphase == 2'd0 && edge_i == vcount) state_next = ST_EMIT;
        else if (fphase == 2'd2) state_next = ST_EDGE;
      end
      ST_EDGE: state_next = qual ? ST_DIV : ST_FETCH;
      ST_DIV: if (div_done) state_next = ST_INS;
      ST_INS: begin
        state_next = ST_FETCH;
        ctl.insert = (ccount < CW'(MAX_CROSSINGS));
      end
      ST_EMIT: begin
        ctl.shift = 1'b1;
        if (emit_load || pairs_left <= CW'(1)) state_next = ST_IDLE;
        else state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        ctl.shift = 1'b1;
        state_next = ST_EMIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // edge test and interpolation product
  always_comb begin
    if (y0 < y1) begin
      dy = y1 - y0; dx = x1 - x0; dyr = row - y0; qual = row >= y0 && row < y1;
    end else begin
      dy = y0 - y1; dx = x0 - x1; dyr = row - y1; qual = row >= y1 && row < y0;
    end
    prod = dx * dyr;
  end

  // edge registers
  always_ff @(posedge clk) begin
    if (state == ST_FETCH && fphase == 2'd1) begin
      x0 <= rd_x; y0 <= rd_y;
    end
    if (state == ST_FETCH && fphase == 2'd2) begin
      x1 <= rd_x; y1 <= rd_y;
    end
    if (state == ST_EDGE) begin
      base_x <= (y0 < y1) ? x0 : x1;
      den <= 17'(dy);
      num <= prod[33] ? 35'(prod) - 35'(dy >>> 1) : 35'(prod) + 35'(dy >>> 1);
    end
  end

  // control and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0; low_y <= '0; high_y <= '0; ccount <= '0;
      fphase <= '0; edge_i <= '0; row <= '0;
      div_start <= 1'b0; pairs_left <= '0; emit_load <= 1'b0; vertex_dropped <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: if (start) begin
          edge_i <= '0; fphase <= '0; row <= row_y; ccount <= '0; pairs_left <= '0;
          emit_load <= (command == CMD_LOAD);
          vertex_dropped <= 1'b0;
          if (command == CMD_LOAD) begin
            if (restart_list || vcount == '0) begin
              vcount <= VW'(1); low_y <= vertex_y; high_y <= vertex_y;
            end else if (vcount >= VW'(MAX_VERTICES)) begin
              vertex_dropped <= 1'b1;
            end else begin
              vcount <= vcount + VW'(1);
              if (vertex_y < low_y) low_y <= vertex_y;
              if (vertex_y > high_y) high_y <= vertex_y;
            end
          end
        end
        ST_FETCH: begin
          if (fphase == 2'd0 && edge_i == vcount) begin
            pairs_left <= ccount >> 1;
          end else if (fphase == 2'd2) begin
            fphase <= '0;
          end else begin
            fphase <= fphase + 2'd1;
          end
        end
        ST_EDGE: begin
          div_start <= qual;
          if (!qual) edge_i <= edge_i + VW'(1);
        end
        ST_DIV: ;
        ST_INS: begin
          edge_i <= edge_i + VW'(1);
          if (ccount < CW'(MAX_CROSSINGS)) ccount <= ccount + CW'(1);
        end
        ST_EMIT: if (pairs_left != '0) pairs_left <= pairs_left - CW'(1);
        default: ;
      endcase
    end
  end

  // output word
  always_comb begin
    span_valid = done && !emit_load && (pairs_left != '0);
    span_x = span_valid ? c_x[0] : 16'sd0;
    span_y = emit_load ? 16'sd0 : row;
    span_length = span_valid ? 16'(c_x[1] - c_x[0] + 16'sd1) : 16'd0;
    span_color = fill_color;
    last_result = emit_load || (pairs_left <= CW'(1));
    vertex_total = 7'(vcount);
    extent_low_y = low_y;
    extent_high_y = high_y;
  end

  `SPF_ASSERT_NEXT(a_done_busy, clk, rst, start && !busy, busy)
  `SPF_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, ccount <= CW'(MAX_CROSSINGS))
  `SPF_ASSERT_IMP(a_vcount_cap, clk, rst, 1'b1, vcount <= VW'(MAX_VERTICES))
  `SPF_ASSERT_IMP(a_empty_last, clk, rst, done && !span_valid, last_result)
endmodule
`default_nettype wire

// ----- rtl/core/spf_cell.sv -----
// ----------------------------------------------------------------------------
// spf_cell
// One slot of the sorted crossing list. On insert a cell keeps its value,
// takes the new x, or takes its left neighbor's value; on shift it takes
// the value from its right neighbor (drain toward the head).
// ----------------------------------------------------------------------------
`default_nettype none
module spf_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spf_pkg::chain_ctl_t ctl,
  input  wire logic signed [15:0] new_x,
  input  wire logic               left_full,
  input  wire logic               left_gt,
  input  wire logic signed [15:0] left_x,
  input  wire logic               right_full,
  input  wire logic signed [15:0] right_x,
  output logic                    full,
  output logic                    gt,
  output logic signed [15:0]      x
);
  import spf_pkg::*;
  assign gt = full && (x > new_x);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      full <= 1'b0;
    end else if (ctl.insert) begin
      full <= full | left_full;
    end else if (ctl.shift) begin
      full <= right_full;
    end
  end

  // value
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (left_gt) begin
        x <= left_x;
      end else if (gt || (!full && left_full)) begin
        x <= new_x;
      end
    end else if (ctl.shift) begin
      x <= right_x;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/spf_div.sv -----
// ----------------------------------------------------------------------------
// spf_div
// Restoring divider: 34-bit magnitude by 17-bit magnitude, one bit a cycle,
// truncating, sign applied at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module spf_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [34:0] num,
  input  wire logic        [16:0] den,
  output logic                    done,
  output logic signed [34:0]      quo
);
  logic [33:0] q;
  logic [16:0] r;
  logic [5:0]  cnt;
  logic        neg;
  logic        run;
  logic [17:0] trial;

  assign trial = {r, q[33]} - {1'b0, den};
  assign quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd34;
        neg <= num[34];
        q <= num[34] ? 34'(-num) : num[33:0];
        r <= '0;
      end else if (run) begin
        if (!trial[17]) begin
          r <= trial[16:0];
          q <= {q[32:0], 1'b1};
        end else begin
          r <= {r[15:0], q[33]};
          q <= {q[32:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the span fill unit: loads polygons, requests rows,
// predicts every span word in a scoreboard and compares each done word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// expected output word
typedef struct {
  logic               valid;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [15:0]        len;
  logic [7:0]         color;
  logic               last;
  logic [6:0]         total;
  logic signed [15:0] low;
  logic signed [15:0] high;
  logic               dropped;
} span_word_t;

// Span scoreboard: own copy of vertex store, extent and fill color
class span_scoreboard;
  logic signed [15:0] store_x[64];
  logic signed [15:0] store_y[64];
  int                 count;
  logic signed [15:0] low_y;
  logic signed [15:0] high_y;
  logic [7:0]         color;
  span_word_t         pending_words[$];
  int                 errors;

  function new();
    count  = 0;
    low_y  = 0;
    high_y = 0;
    color  = 0;
    errors = 0;
  endfunction

  function void set_color(logic [7:0] c);
    color = c;
  endfunction

  function span_word_t status_word(logic valid, logic signed [15:0] x,
                                   logic signed [15:0] y, logic [15:0] len,
                                   logic last, logic dropped);
    span_word_t w;
    w.valid = valid; w.x = x; w.y = y; w.len = len; w.color = color;
    w.last = last; w.total = count[6:0]; w.low = low_y; w.high = high_y;
    w.dropped = dropped;
    return w;
  endfunction

  // crossings of one row, sorted and capped at 16
  function void predict_spans(logic signed [15:0] row);
    logic signed [15:0] xs[16];
    int     n, i, j, k, pairs;
    longint x0, y0, x1, y1, lx, ly, hx, hy, dx, dy, num, add, cx;
    n = 0;
    if (count >= 3) begin
      for (i = 0; i < count; i++) begin
        j  = (i + 1 < count) ? i + 1 : 0;
        x0 = store_x[i]; y0 = store_y[i]; x1 = store_x[j]; y1 = store_y[j];
        if (y0 == y1) continue;
        if (y0 < y1) begin
          lx = x0; ly = y0; hx = x1; hy = y1;
        end else begin
          lx = x1; ly = y1; hx = x0; hy = y0;
        end
        if (row < ly || row >= hy) continue;
        dx  = hx - lx;
        dy  = hy - ly;
        num = dx * (row - ly);
        add = (num >= 0) ? dy / 2 : -(dy / 2);
        cx  = lx + (num + add) / dy;
        if (n >= 16) continue;
        k = n;
        while (k > 0 && xs[k-1] > cx) begin
          xs[k] = xs[k-1];
          k--;
        end
        xs[k] = cx[15:0];
        n++;
      end
    end
    pairs = n / 2;
    if (pairs == 0)
      pending_words.push_back(status_word(1'b0, 16'sd0, row, 16'd0, 1'b1, 1'b0));
    for (k = 0; k < pairs; k++)
      pending_words.push_back(status_word(1'b1, xs[2*k], row,
                              16'(xs[2*k+1] - xs[2*k] + 1), k + 1 == pairs, 1'b0));
  endfunction

  // note one accepted command word
  function void record_command(logic cmd, logic restart, logic signed [15:0] vx,
                               logic signed [15:0] vy, logic signed [15:0] row);
    logic dropped;
    dropped = 1'b0;
    if (cmd == spf_pkg::CMD_ROW) begin
      predict_spans(row);
    end else begin
      if (restart) count = 0;
      if (count >= 64) begin
        dropped = 1'b1;
      end else begin
        store_x[count] = vx;
        store_y[count] = vy;
        if (count == 0) begin
          low_y = vy; high_y = vy;
        end else begin
          if (vy < low_y) low_y = vy;
          if (vy > high_y) high_y = vy;
        end
        count++;
      end
      pending_words.push_back(status_word(1'b0, 16'sd0, 16'sd0, 16'd0, 1'b1, dropped));
    end
  endfunction

  function void field(string name, longint exp, longint act);
    if (exp != act) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp, act);
    end
  endfunction

  // compare one output word with the oldest expectation
  function void compare_word(span_word_t got);
    span_word_t e;
    if (pending_words.size() == 0) begin
      errors++;
      $error("unexpected output word");
      return;
    end
    e = pending_words.pop_front();
    field("span_valid", e.valid, got.valid);
    field("span_x", e.x, got.x);
    field("span_y", e.y, got.y);
    field("span_length", e.len, got.len);
    field("span_color", e.color, got.color);
    field("last_result", e.last, got.last);
    field("vertex_total", e.total, got.total);
    field("extent_low_y", e.low, got.low);
    field("extent_high_y", e.high, got.high);
    field("vertex_dropped", e.dropped, got.dropped);
  endfunction
endclass

module tb_top;
  import spf_pkg::*;

  logic clk, rst, start, busy;
  logic command, restart_list;
  logic signed [15:0] vertex_x, vertex_y, row_y;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_data;
  logic done, span_valid, last_result, vertex_dropped;
  logic signed [15:0] span_x, span_y, extent_low_y, extent_high_y;
  logic [15:0] span_length;
  logic [7:0] span_color;
  logic [6:0] vertex_total;

  span_scoreboard sb;
  int items_sent;
  int burst_left;
  int cycles;

  scanline_polygon_span_fill_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .restart_list(restart_list),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .row_y(row_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .span_valid(span_valid), .span_x(span_x), .span_y(span_y),
    .span_length(span_length), .span_color(span_color),
    .last_result(last_result), .vertex_total(vertex_total),
    .extent_low_y(extent_low_y), .extent_high_y(extent_high_y),
    .vertex_dropped(vertex_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // output monitor: every done word is sampled on its single cycle
  always @(posedge clk) begin
    span_word_t w;
    if (!rst && done) begin
      w.valid = span_valid; w.x = span_x; w.y = span_y; w.len = span_length;
      w.color = span_color; w.last = last_result; w.total = vertex_total;
      w.low = extent_low_y; w.high = extent_high_y; w.dropped = vertex_dropped;
      sb.compare_word(w);
    end
  end

  // send one command word; start stays high across back-to-back words
  task automatic send_word(logic cmd, logic restart, logic signed [15:0] vx,
                           logic signed [15:0] vy, logic signed [15:0] row);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 25);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    command      <= cmd;
    restart_list <= restart;
    vertex_x     <= vx;
    vertex_y     <= vy;
    row_y        <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.record_command(cmd, restart, vx, vy, row);
    items_sent++;
  endtask

  task automatic load_vertex(logic restart, int x, int y);
    send_word(CMD_LOAD, restart, 16'(x), 16'(y), 16'($urandom));
  endtask

  task automatic request_row(int row);
    send_word(CMD_ROW, 1'($urandom), 16'($urandom), 16'($urandom), 16'(row));
  endtask

  // write fill color once all words are back
  task automatic write_color(logic [7:0] c);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_color(c);
  endtask

  // random polygon and a handful of rows over it
  task automatic random_polygon();
    int n, i, r, span, lo, hi;
    logic wide;
    n    = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(3, 10);
    wide = ($urandom_range(0, 3) == 0);
    span = $urandom_range(4, 300);
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 2);
    for (i = 0; i < n; i++) begin
      if (wide) load_vertex(i == 0, $signed(16'($urandom)), $signed(16'($urandom)));
      else load_vertex(i == 0, $urandom_range(0, 2*span) - span,
                       $urandom_range(0, 2*span) - span);
    end
    lo = sb.low_y;
    hi = sb.high_y;
    for (i = 0; i < 6; i++) begin
      if ($urandom_range(0, 4) == 0) r = $signed(16'($urandom));
      else r = lo - 1 + $urandom_range(0, hi - lo + 2);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      request_row(r);
    end
  endtask

  // zigzag outline: more crossings than the list holds
  task automatic zigzag_polygon();
    int i, base;
    base = $urandom_range(0, 1000) - 500;
    for (i = 0; i < 30; i++)
      load_vertex(i == 0, base + i * 10, (i % 2) ? 100 : 0);
    request_row(50);
    request_row(0);
    request_row($urandom_range(1, 99));
  endtask

  initial begin
    int i;
    logic [7:0] colors[4];
    sb = new();
    items_sent = 0;
    burst_left = 0;
    rst = 1'b1;
    start = 1'b0; command = 1'b0; restart_list = 1'b0;
    vertex_x = '0; vertex_y = '0; row_y = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, short lists, extremes, horizontal edges
    write_color(8'hFF);
    request_row(0);
    load_vertex(1'b1, -32768, -32768);
    load_vertex(1'b0, 32767, 32767);
    request_row(0);
    load_vertex(1'b0, -32768, 32767);
    request_row(-32768);
    request_row(32767);
    request_row(32766);
    request_row(0);
    request_row(-1);
    load_vertex(1'b1, 0, 0);
    load_vertex(1'b0, 10, 0);
    load_vertex(1'b0, 10, 10);
    load_vertex(1'b0, 0, 10);
    request_row(-1);
    request_row(0);
    request_row(9);
    request_row(10);
    load_vertex(1'b1, 32767, -32768);
    load_vertex(1'b0, -32768, -32768);
    load_vertex(1'b0, 0, 32767);
    request_row(-32768);
    request_row(-3);

    // random phases with color changes between them
    colors[0] = 8'h00; colors[1] = 8'hFF; colors[2] = 8'h5A; colors[3] = 8'hA5;
    i = 0;
    while (items_sent < 160) begin
      if (i % 3 == 0)
        write_color((i / 3 < 4) ? colors[i / 3] : 8'($urandom));
      if (i == 5) zigzag_polygon();
      else random_polygon();
      i++;
    end

    // full store: extra loads are dropped
    for (i = 0; i < 66; i++)
      load_vertex(i == 0, $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
    request_row(0);
    request_row(sb.low_y);

    start <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire

// ----- scanline_polygon_span_fill_unit.f -----
+incdir+rtl/core
rtl/core/spf_pkg.sv
rtl/core/spf_cell.sv
rtl/core/spf_div.sv
rtl/core/scanline_polygon_span_fill_unit.sv
tb/tb_top.sv
